@@ rtl/fbt_pkg.sv @@
package fbt_pkg;

  // configuration register indexes
  localparam logic [7:0] CFG_INTERP = 8'd0;
  localparam logic [7:0] CFG_COLOR  = 8'd1;

  // one input sample
  typedef struct packed {
    logic               first_sample;
    logic signed [31:0] x_coord;
    logic signed [31:0] upper_y;
    logic signed [31:0] lower_y;
    logic               sample_finite;
    logic               where_flag;
  } in_item_t;

  // one emitted triangle
  typedef struct packed {
    logic signed [31:0] vert_a_x;
    logic signed [31:0] vert_a_y;
    logic signed [31:0] vert_b_x;
    logic signed [31:0] vert_b_y;
    logic signed [31:0] vert_c_x;
    logic signed [31:0] vert_c_y;
    logic        [31:0] tri_color;
    logic               last_of_item;
  } out_item_t;

  // work handed from the front to the back
  typedef enum logic [1:0] {
    JOB_PEND       = 2'd0,
    JOB_QUAD       = 2'd1,
    JOB_QUAD_START = 2'd2,
    JOB_END        = 2'd3
  } job_kind_t;

  typedef struct packed {
    job_kind_t          kind;
    logic signed [31:0] px;
    logic signed [31:0] pu;
    logic signed [31:0] pl;
    logic signed [31:0] cx;
    logic signed [31:0] cu;
    logic signed [31:0] cl;
  } job_t;

endpackage

@@ rtl/fill_between_triangle_emitter.sv @@
// Fill-between triangle emitter.
// Input channel in_valid/in_ready/in_data carries curve samples in order;
// output channel out_valid/out_ready/out_data carries triangles, the final
// one caused by a sample marked by last_of_item. Config channel
// cfg_valid/cfg_ready/cfg_index/cfg_data writes interpolate_ends (index 0)
// and fill_color (index 1); it is always ready and should be used only
// while the block is idle.
// A front stage tracks runs and takes a sample each cycle while the job
// queue has room; samples that produce nothing leave no job. The back
// sequencer runs the jobs: a quad takes a start step and then emits its
// triangles (2 or 3) one per cycle unless the output stalls. A crossing
// (run start with a neighbour, or run end) runs the shared clamped
// interpolation twice; each pass is a setup step, plus a divide by the
// one-bit-per-cycle divider, a multiply and a final add when the point is
// not clamped, and an end triangle then passes through the emit state to
// the output register. The first triangle of a quad passes from the job
// queue through the emit state to the output register.
// Reset clears run state, the queue, the config registers and out_valid.
// A stalled receiver holds the output register; the queue then fills and
// in_ready drops once it is full.
module fill_between_triangle_emitter #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  fbt_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output fbt_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int CW = $clog2(QUEUE_DEPTH+1);

  logic          interpolate_ends;
  logic [31:0]   fill_color;
  logic          q_push;
  logic          q_pop;
  logic          q_empty;
  logic          q_full;
  logic [CW-1:0] q_count;
  fbt_pkg::job_t q_in;
  fbt_pkg::job_t q_out;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      interpolate_ends <= 1'b0;
      fill_color       <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        fbt_pkg::CFG_INTERP: interpolate_ends <= cfg_data[0];
        fbt_pkg::CFG_COLOR:  fill_color       <= cfg_data;
        default: ;
      endcase
    end
  end

  fbt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .interp   (interpolate_ends),
    .q_full   (q_full),
    .push     (q_push),
    .push_job (q_in)
  );

  fbt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty),
    .full      (q_full),
    .count     (q_count)
  );

  fbt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (q_out),
    .pop       (q_pop),
    .color     (fill_color),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // queue level stays within its depth
  assert property (@(posedge clk) disable iff (rst) q_count <= CW'(QUEUE_DEPTH))
    else $error("job queue level beyond depth");

  // a run-end job is only queued with end interpolation on
  assert property (@(posedge clk) disable iff (rst)
    q_push && q_in.kind == fbt_pkg::JOB_END |-> interpolate_ends)
    else $error("end job queued without interpolation");

  // no push into a full queue
  assert property (@(posedge clk) disable iff (rst) q_full |-> !q_push)
    else $error("push into full job queue");

  // nothing is shown right after reset
  assert property (@(posedge clk) !rst && $past(rst) |-> !out_valid)
    else $error("output valid after reset");

endmodule

@@ rtl/fbt_front.sv @@
module fbt_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  fbt_pkg::in_item_t in_data,
  input  logic            interp,
  input  logic            q_full,
  output logic            push,
  output fbt_pkg::job_t   push_job
);

  logic signed [31:0] prev_x;
  logic signed [31:0] prev_upper;
  logic signed [31:0] prev_lower;
  logic [1:0] run_count;
  logic       run_has_left_neighbour;
  logic       seen_sample;

  logic [1:0] rc_eff;
  logic       left_eff;
  logic       seen_eff;
  logic       smp_ok;
  logic       accept;
  logic       need;
  fbt_pkg::job_kind_t kind;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // run state as seen by this sample, after a new set clears it
  assign rc_eff   = in_data.first_sample ? 2'd0 : run_count;
  assign left_eff = in_data.first_sample ? 1'b0 : run_has_left_neighbour;
  assign seen_eff = in_data.first_sample ? 1'b0 : seen_sample;
  assign smp_ok   = in_data.sample_finite && in_data.where_flag;

  // classify the sample
  always_comb begin
    need = 1'b0;
    kind = fbt_pkg::JOB_QUAD;
    if (smp_ok) begin
      if (rc_eff == 2'd0) begin
        need = seen_eff;
        kind = fbt_pkg::JOB_PEND;
      end else begin
        need = 1'b1;
        kind = (rc_eff == 2'd1 && left_eff && interp) ? fbt_pkg::JOB_QUAD_START
                                                      : fbt_pkg::JOB_QUAD;
      end
    end else begin
      need = (rc_eff == 2'd2) && interp;
      kind = fbt_pkg::JOB_END;
    end
  end

  assign push           = accept && need;
  assign push_job.kind  = kind;
  assign push_job.px    = prev_x;
  assign push_job.pu    = prev_upper;
  assign push_job.pl    = prev_lower;
  assign push_job.cx    = in_data.x_coord;
  assign push_job.cu    = in_data.upper_y;
  assign push_job.cl    = in_data.lower_y;

  // run tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      run_count              <= 2'd0;
      run_has_left_neighbour <= 1'b0;
      seen_sample            <= 1'b0;
    end else if (accept) begin
      seen_sample            <= 1'b1;
      run_has_left_neighbour <= left_eff;
      if (smp_ok) begin
        if (rc_eff == 2'd0) begin
          run_has_left_neighbour <= seen_eff;
          run_count              <= 2'd1;
        end else begin
          run_count <= 2'd2;
        end
      end else begin
        run_count <= 2'd0;
      end
    end
  end

  // previous sample
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x     <= '0;
      prev_upper <= '0;
      prev_lower <= '0;
    end else if (accept) begin
      prev_x     <= in_data.x_coord;
      prev_upper <= in_data.upper_y;
      prev_lower <= in_data.lower_y;
    end
  end

endmodule

@@ rtl/fbt_queue.sv @@
module fbt_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  fbt_pkg::job_t push_data,
  input  logic          pop,
  output fbt_pkg::job_t pop_data,
  output logic          empty,
  output logic          full,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  fbt_pkg::job_t mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;

  assign empty    = (count == '0);
  assign full     = (count == CW'(DEPTH));
  assign pop_data = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/fbt_back.sv @@
module fbt_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  fbt_pkg::job_t     q_data,
  output logic              pop,
  input  logic [31:0]       color,
  output logic              out_valid,
  input  logic              out_ready,
  output fbt_pkg::out_item_t out_data
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SETUP = 6'b000010,
    S_DIV   = 6'b000100,
    S_MUL   = 6'b001000,
    S_ADD   = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t state;
  fbt_pkg::job_t job;
  logic       phase;
  logic [1:0] idx;

  // shared clamped-interpolation operands
  logic signed [33:0] lt;
  logic signed [33:0] lp0;
  logic signed [33:0] lp1;
  logic signed [31:0] lf0;
  logic signed [31:0] lf1;
  logic [33:0] rem;
  logic [33:0] den;
  logic [31:0] w;
  logic [4:0]  cnt;
  logic [32:0] mag;
  logic        neg;
  logic [63:0] prod;

  logic signed [31:0] cross_x;
  logic signed [31:0] pend_x;
  logic signed [31:0] pend_y;

  // job decode at the head of the queue
  logic signed [33:0] d0;
  logic signed [33:0] d1;
  logic signed [32:0] fdiff;

  // setup checks
  logic        triv;
  logic signed [31:0] triv_res;

  // divider step and final sum
  logic [34:0] shifted;
  logic [65:0] sum;
  logic [32:0] q;
  logic signed [33:0] add_res;

  logic        fin;
  logic signed [31:0] fin_res;
  logic        load;
  logic        last;
  fbt_pkg::out_item_t tri_d;

  assign pop = (state == S_IDLE) && !q_empty;

  always_comb begin
    d0 = 34'(q_data.pu) - 34'(q_data.pl);
    d1 = 34'(q_data.cu) - 34'(q_data.cl);
  end

  // trivial cases of the clamped interpolation
  always_comb begin
    triv     = (lp0 == lp1) || (lt <= lp0) || (lt >= lp1);
    if (lp0 == lp1) begin
      triv_res = (lt < lp0) ? lf0 : lf1;
    end else begin
      triv_res = (lt <= lp0) ? lf0 : lf1;
    end
    fdiff = 33'(lf1) - 33'(lf0);
  end

  // restoring division step and rounded scaling
  always_comb begin
    shifted = {rem, 1'b0};
    sum     = {2'b00, prod} + (mag[32] ? {2'b00, w, 32'd0} : 66'd0)
              + 66'h0_8000_0000;
    q       = sum[64:32];
    add_res = neg ? (34'(lf0) - $signed({1'b0, q})) : (34'(lf0) + $signed({1'b0, q}));
  end

  always_comb begin
    fin     = 1'b0;
    fin_res = triv_res;
    if (state == S_SETUP && triv) begin
      fin = 1'b1;
    end else if (state == S_ADD) begin
      fin     = 1'b1;
      fin_res = add_res[31:0];
    end
  end

  // triangle for the current emit slot
  always_comb begin
    tri_d.tri_color = color;
    tri_d.vert_b_x  = job.px;
    tri_d.vert_b_y  = job.pu;
    tri_d.vert_c_x  = job.px;
    tri_d.vert_c_y  = job.pl;
    tri_d.vert_a_x  = pend_x;
    tri_d.vert_a_y  = pend_y;
    last = 1'b0;
    case (job.kind)
      fbt_pkg::JOB_END: begin
        tri_d.vert_a_x = cross_x;
        tri_d.vert_a_y = pend_y;
        last = 1'b1;
      end
      default: begin
        if (idx == 2'd0) begin
          tri_d.vert_a_x = job.px;
          tri_d.vert_a_y = job.pu;
          tri_d.vert_b_x = job.cx;
          tri_d.vert_b_y = job.cu;
        end else if (idx == 2'd1) begin
          tri_d.vert_a_x = job.cx;
          tri_d.vert_a_y = job.cu;
          tri_d.vert_b_x = job.cx;
          tri_d.vert_b_y = job.cl;
        end
        last = (job.kind == fbt_pkg::JOB_QUAD_START) ? (idx == 2'd2) : (idx == 2'd1);
      end
    endcase
    tri_d.last_of_item = last;
  end

  assign load = (state == S_EMIT) && (!out_valid || out_ready);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= 1'b0;
      idx   <= 2'd0;
    end else begin
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            idx   <= 2'd0;
            phase <= 1'b0;
            if (q_data.kind == fbt_pkg::JOB_QUAD ||
                q_data.kind == fbt_pkg::JOB_QUAD_START) begin
              state <= S_EMIT;
            end else begin
              state <= S_SETUP;
            end
          end
        end
        S_SETUP: begin
          if (!triv) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (cnt == 5'd31) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_ADD;
        end
        S_ADD: begin
          state <= S_SETUP;
        end
        S_EMIT: begin
          if (load) begin
            if (last) begin
              state <= S_IDLE;
            end else begin
              idx <= idx + 2'd1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      // an interpolation finished
      if (fin) begin
        if (!phase) begin
          phase <= 1'b1;
          state <= S_SETUP;
        end else if (job.kind == fbt_pkg::JOB_PEND) begin
          state <= S_IDLE;
        end else begin
          state <= S_EMIT;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (pop) begin
      job <= q_data;
      lt  <= '0;
      if (d0 > d1) begin
        lp0 <= d1;
        lp1 <= d0;
        lf0 <= q_data.cx;
        lf1 <= q_data.px;
      end else begin
        lp0 <= d0;
        lp1 <= d1;
        lf0 <= q_data.px;
        lf1 <= q_data.cx;
      end
    end
    if (state == S_SETUP) begin
      rem <= 34'(lt - lp0);
      den <= 34'(lp1 - lp0);
      w   <= '0;
      cnt <= '0;
      mag <= fdiff[32] ? 33'(-fdiff) : 33'(fdiff);
      neg <= fdiff[32];
    end
    if (state == S_DIV) begin
      cnt <= cnt + 5'd1;
      if (shifted >= {1'b0, den}) begin
        rem <= 34'(shifted - {1'b0, den});
        w   <= {w[30:0], 1'b1};
      end else begin
        rem <= shifted[33:0];
        w   <= {w[30:0], 1'b0};
      end
    end
    if (state == S_MUL) begin
      prod <= mag[31:0] * w;
    end
    if (fin) begin
      if (!phase) begin
        cross_x <= fin_res;
        lt      <= 34'(fin_res);
        if (job.px <= job.cx) begin
          lp0 <= 34'(job.px);
          lp1 <= 34'(job.cx);
          lf0 <= job.pu;
          lf1 <= job.cu;
        end else begin
          lp0 <= 34'(job.cx);
          lp1 <= 34'(job.px);
          lf0 <= job.cu;
          lf1 <= job.pu;
        end
      end else begin
        pend_y <= fin_res;
        if (job.kind == fbt_pkg::JOB_PEND) begin
          pend_x <= cross_x;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= tri_d;
    end
  end

endmodule
